@@ hw/rtl/srtc_pkg.sv @@
package srtc_pkg;

  localparam int PRAM_BYTES = 256;
  localparam int PRAM_AW    = $clog2(PRAM_BYTES);

  localparam logic [7:0] LOW_GROUP_BASE  = 8'h08;
  localparam logic [7:0] HIGH_GROUP_BASE = 8'h10;
  localparam logic [7:0] EXT_CMD_MASK    = 8'h78;
  localparam logic [7:0] EXT_CMD_CODE    = 8'h38;

  // Register numbers taken from bits 6..2 of a standard command.
  localparam logic [4:0] REG_LOW_GROUP  = 5'd8;
  localparam logic [4:0] REG_TEST       = 5'd12;
  localparam logic [4:0] REG_WPROTECT   = 5'd13;
  localparam logic [4:0] REG_HIGH_GROUP = 5'd16;
  localparam logic [4:0] REG_UNKNOWN_LO = 5'd12;

  typedef enum logic [1:0] {
    MODE_CLOCK  = 2'd0,
    MODE_ENABLE = 2'd1,
    MODE_TIME   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_WRITE_UNKNOWN = 2'd1,
    ST_READ_UNKNOWN  = 2'd2,
    ST_ABORTED       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_CMD     = 2'd0,
    PH_DATA    = 2'd1,
    PH_EXT     = 2'd2,
    PH_EXTDATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic    val;
    logic    drv;
    logic    pulse;
    status_t status;
  } result_t;

endpackage

@@ hw/rtl/serial_rtc_with_pram.sv @@
// Throughput: one word per cycle while in_stall is low; a parameter RAM read
// is registered in the RAM and forwarded to the next word, so nothing waits
// on it. A two-entry output queue lets input continue while one result is
// held. Reset (synchronous, active high) clears the control state but not
// the RAM, the queue entries or the read valid flag; the parameter RAM reads
// as zero through per-entry valid bits, so no clearing pass is needed.
module serial_rtc_with_pram (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        clock_level,
  input  logic        chip_disabled,
  input  logic        data_in,
  input  logic [31:0] host_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        data_line_value,
  output logic        data_line_driven,
  output logic        second_pulse,
  output logic [1:0]  status
);
  import srtc_pkg::*;

  logic    go;
  logic    full;
  result_t res;
  result_t head;

  assign in_stall = full;
  assign go       = in_valid && !full;

  srtc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .mode          (mode),
    .clock_level   (clock_level),
    .chip_disabled (chip_disabled),
    .data_in       (data_in),
    .host_seconds  (host_seconds),
    .res           (res)
  );

  srtc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (go),
    .push_word (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign data_line_value  = head.val;
  assign data_line_driven = head.drv;
  assign second_pulse     = head.pulse;
  assign status           = head.status;

  a_stall_only_when_holding: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output queue");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  a_value_only_when_driven: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!data_line_value || data_line_driven))
    else $error("data line value set without driving the line");

  a_pulse_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && second_pulse) |-> (status == ST_OK && !data_line_driven))
    else $error("second pulse combined with a serial result");

endmodule

@@ hw/rtl/srtc_ram.sv @@
module srtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hw/rtl/srtc_outq.sv @@
module srtc_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  srtc_pkg::result_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output srtc_pkg::result_t head
);
  import srtc_pkg::*;

  // Two-entry queue: entry0 is the head, entry1 the skid slot.
  result_t     entry0;
  result_t     entry1;
  logic [1:0]  count;
  logic        pop;

  assign pop       = (count != 2'd0) && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          entry0 <= push_word;
        end else begin
          entry1 <= push_word;
        end
      end
      2'b01: entry0 <= entry1;
      2'b11: entry0 <= push_word;
      default: entry0 <= entry0;
    endcase
  end

endmodule

@@ hw/rtl/srtc_core.sv @@
module srtc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [1:0]        mode,
  input  logic              clock_level,
  input  logic              chip_disabled,
  input  logic              data_in,
  input  logic [31:0]       host_seconds,
  output srtc_pkg::result_t res
);
  import srtc_pkg::*;

  logic [7:0]            shift_byte, shift_byte_next, shift_cur;
  logic                  from_ram, from_ram_next;
  logic                  ram_vld_q;
  logic                  send_pending, send_pending_next;
  logic [2:0]            bit_count, bit_count_next, bc_dec;
  phase_t                phase, phase_next;
  logic [7:0]            held_command, held_command_next;
  logic [7:0]            extended_address, extended_address_next;
  logic [31:0]           seconds, seconds_next;
  logic [31:0]           last_host_seconds, last_host_seconds_next;
  logic [31:0]           delta;
  logic                  wr_locked, wr_locked_next;
  logic [PRAM_BYTES-1:0] pram_valid;
  logic                  ram_we, ram_re;
  logic [PRAM_AW-1:0]    ram_addr;
  logic [7:0]            ram_rdata;
  logic [7:0]            byte_in;
  logic [4:0]            sel_rd, sel_wr;

  srtc_ram #(.WIDTH(8), .DEPTH(PRAM_BYTES)) u_pram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (byte_in),
    .rdata (ram_rdata)
  );

  // A read issued by the previous word is taken from the registered RAM output;
  // an entry never written reads as zero.
  assign shift_cur = from_ram ? (ram_vld_q ? ram_rdata : 8'h00) : shift_byte;
  assign byte_in   = {shift_cur[6:0], data_in};
  assign bc_dec    = bit_count - 3'd1;
  assign sel_rd    = byte_in[6:2];
  assign sel_wr    = held_command[6:2];
  assign delta     = host_seconds - last_host_seconds;

  always_comb begin
    shift_byte_next        = shift_cur;
    from_ram_next          = 1'b0;
    send_pending_next      = send_pending;
    bit_count_next         = bit_count;
    phase_next             = phase;
    held_command_next      = held_command;
    extended_address_next  = extended_address;
    seconds_next           = seconds;
    last_host_seconds_next = last_host_seconds;
    wr_locked_next         = wr_locked;
    ram_we                 = 1'b0;
    ram_re                 = 1'b0;
    ram_addr               = '0;
    res                    = '{val: 1'b0, drv: 1'b0, pulse: 1'b0, status: ST_OK};
    if (go) begin
      unique case (mode_t'(mode))
        MODE_CLOCK: begin
          if (!chip_disabled && clock_level) begin
            bit_count_next = bc_dec;
            if (send_pending) begin
              res.val = shift_cur[bc_dec];
              res.drv = 1'b1;
              if (bc_dec == 3'd0) begin
                send_pending_next = 1'b0;
              end
            end else begin
              shift_byte_next = byte_in;
              if (bc_dec == 3'd0) begin
                unique case (phase)
                  PH_CMD: begin
                    if ((byte_in & EXT_CMD_MASK) == EXT_CMD_CODE) begin
                      held_command_next = byte_in;
                      phase_next        = PH_EXT;
                    end else if (byte_in[7]) begin
                      send_pending_next = 1'b1;
                      priority if (sel_rd < REG_LOW_GROUP) begin
                        shift_byte_next = seconds[{sel_rd[1:0], 3'b000} +: 8];
                      end else if (sel_rd < REG_UNKNOWN_LO) begin
                        ram_re        = 1'b1;
                        from_ram_next = 1'b1;
                        ram_addr      = PRAM_AW'({LOW_GROUP_BASE[7:2], sel_rd[1:0]});
                      end else if (sel_rd < REG_HIGH_GROUP) begin
                        res.status      = ST_READ_UNKNOWN;
                        shift_byte_next = 8'h00;
                      end else begin
                        ram_re        = 1'b1;
                        from_ram_next = 1'b1;
                        ram_addr      = PRAM_AW'({HIGH_GROUP_BASE[7:4], sel_rd[3:0]});
                      end
                    end else begin
                      held_command_next = byte_in;
                      phase_next        = PH_DATA;
                    end
                  end
                  PH_DATA: begin
                    phase_next = PH_CMD;
                    priority if (sel_wr < REG_LOW_GROUP) begin
                      if (!wr_locked) begin
                        seconds_next[{sel_wr[1:0], 3'b000} +: 8] = byte_in;
                      end
                    end else if (sel_wr < REG_UNKNOWN_LO) begin
                      ram_we   = !wr_locked;
                      ram_addr = PRAM_AW'({LOW_GROUP_BASE[7:2], sel_wr[1:0]});
                    end else if (sel_wr == REG_WPROTECT) begin
                      wr_locked_next = byte_in[7];
                    end else if (sel_wr < REG_HIGH_GROUP) begin
                      // The test register swallows writes silently.
                      if (sel_wr != REG_TEST) begin
                        res.status = ST_WRITE_UNKNOWN;
                      end
                    end else begin
                      ram_we   = !wr_locked;
                      ram_addr = PRAM_AW'({HIGH_GROUP_BASE[7:4], sel_wr[3:0]});
                    end
                  end
                  PH_EXT: begin
                    extended_address_next = {held_command[2:0], byte_in[6:2]};
                    if (held_command[7]) begin
                      ram_re            = 1'b1;
                      from_ram_next     = 1'b1;
                      send_pending_next = 1'b1;
                      ram_addr          = PRAM_AW'({held_command[2:0], byte_in[6:2]});
                      phase_next        = PH_CMD;
                    end else begin
                      phase_next = PH_EXTDATA;
                    end
                  end
                  PH_EXTDATA: begin
                    ram_we     = !wr_locked;
                    ram_addr   = PRAM_AW'(extended_address);
                    phase_next = PH_CMD;
                  end
                endcase
              end
            end
          end
        end
        MODE_ENABLE: begin
          if (chip_disabled) begin
            if (bit_count != 3'd0) begin
              res.status = ST_ABORTED;
            end
            phase_next        = PH_CMD;
            send_pending_next = 1'b0;
            shift_byte_next   = 8'h00;
            bit_count_next    = 3'd0;
          end
        end
        MODE_TIME: begin
          if (delta != 32'd0) begin
            seconds_next           = seconds + delta;
            last_host_seconds_next = host_seconds;
            res.pulse              = 1'b1;
          end
        end
        MODE_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte        <= 8'h00;
      from_ram          <= 1'b0;
      send_pending      <= 1'b0;
      bit_count         <= 3'd0;
      phase             <= PH_CMD;
      held_command      <= 8'h00;
      extended_address  <= 8'h00;
      seconds           <= 32'd0;
      last_host_seconds <= 32'd0;
      wr_locked         <= 1'b0;
      pram_valid        <= '0;
    end else begin
      shift_byte        <= shift_byte_next;
      from_ram          <= from_ram_next;
      send_pending      <= send_pending_next;
      bit_count         <= bit_count_next;
      phase             <= phase_next;
      held_command      <= held_command_next;
      extended_address  <= extended_address_next;
      seconds           <= seconds_next;
      last_host_seconds <= last_host_seconds_next;
      wr_locked         <= wr_locked_next;
      if (ram_we) begin
        pram_valid[ram_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      ram_vld_q <= pram_valid[ram_addr];
    end
  end

endmodule

@@ dv/serial_rtc_with_pram_tb.sv @@
module serial_rtc_with_pram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srtc_pkg::*;

  // Tracks the clock chip's state word by word and holds the results it owes.
  class rtc_event_checker;
    logic       wprot;
    logic       sending;
    logic       send_pend;
    logic [7:0] shreg;
    logic [2:0] nbits;
    phase_t     phase;
    logic [7:0] held_cmd;
    logic [7:0] ext_addr;
    logic [7:0] secs [4];
    logic [7:0] pram [PRAM_BYTES];
    logic [31:0] last_host;
    status_t    word_status;
    result_t    due_results [$];
    int         fails;

    function new();
      wprot = 1'b0;
      sending = 1'b0;
      send_pend = 1'b0;
      shreg = '0;
      nbits = '0;
      phase = PH_CMD;
      held_cmd = '0;
      ext_addr = '0;
      last_host = '0;
      fails = 0;
      foreach (secs[i]) secs[i] = '0;
      foreach (pram[i]) pram[i] = '0;
    endfunction

    function void store_pram(logic [7:0] addr, logic [7:0] v);
      if (!wprot) pram[addr] = v;
    endfunction

    function logic [7:0] access_reg(logic [7:0] cmd, logic wr, logic [7:0] v);
      logic [4:0] rn;
      rn = cmd[6:2];
      if (rn < REG_LOW_GROUP) begin
        if (wr) begin
          if (!wprot) secs[rn[1:0]] = v;
          return v;
        end
        return secs[rn[1:0]];
      end
      if (rn < REG_TEST) begin
        if (wr) begin
          store_pram(LOW_GROUP_BASE + {6'b0, rn[1:0]}, v);
          return v;
        end
        return pram[LOW_GROUP_BASE + {6'b0, rn[1:0]}];
      end
      if (rn < REG_HIGH_GROUP) begin
        if (wr) begin
          if (rn == REG_WPROTECT) wprot = v[7];
          else if (rn != REG_TEST) word_status = ST_WRITE_UNKNOWN;
          return v;
        end
        word_status = ST_READ_UNKNOWN;
        return 8'h00;
      end
      if (wr) begin
        store_pram(HIGH_GROUP_BASE + {4'b0, rn[3:0]}, v);
        return v;
      end
      return pram[HIGH_GROUP_BASE + {4'b0, rn[3:0]}];
    endfunction

    function void decode_byte();
      case (phase)
        PH_CMD: begin
          if ((shreg & EXT_CMD_MASK) == EXT_CMD_CODE) begin
            held_cmd = shreg;
            phase = PH_EXT;
          end else if (shreg[7]) begin
            shreg = access_reg(shreg, 1'b0, 8'h00);
            send_pend = 1'b1;
          end else begin
            held_cmd = shreg;
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          void'(access_reg(held_cmd, 1'b1, shreg));
          phase = PH_CMD;
        end
        PH_EXT: begin
          ext_addr = {held_cmd[2:0], shreg[6:2]};
          if (held_cmd[7]) begin
            shreg = pram[ext_addr];
            send_pend = 1'b1;
            phase = PH_CMD;
          end else begin
            phase = PH_EXTDATA;
          end
        end
        default: begin
          store_pram(ext_addr, shreg);
          phase = PH_CMD;
        end
      endcase
    endfunction

    function void take_event(logic [1:0] m, logic clk_lvl, logic dis, logic din,
                             logic [31:0] host);
      result_t r;
      logic [31:0] delta;
      logic [31:0] count;
      r = '0;
      word_status = ST_OK;
      case (m)
        MODE_CLOCK: begin
          if (!dis && clk_lvl) begin
            sending = send_pend;
            nbits = nbits - 3'd1;
            if (sending) begin
              r.val = shreg[nbits];
              r.drv = 1'b1;
              if (nbits == 3'd0) send_pend = 1'b0;
            end else begin
              shreg = {shreg[6:0], din};
              if (nbits == 3'd0) decode_byte();
            end
          end
        end
        MODE_ENABLE: begin
          if (dis) begin
            if (nbits != 3'd0) word_status = ST_ABORTED;
            phase = PH_CMD;
            sending = 1'b0;
            send_pend = 1'b0;
            shreg = '0;
            nbits = '0;
          end
        end
        MODE_TIME: begin
          delta = host - last_host;
          if (delta != 0) begin
            count = {secs[3], secs[2], secs[1], secs[0]} + delta;
            {secs[3], secs[2], secs[1], secs[0]} = count;
            last_host = host;
            r.pulse = 1'b1;
          end
        end
        default: ;
      endcase
      r.status = word_status;
      due_results.push_back(r);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result word arrived with nothing outstanding");
        fails++;
        return;
      end
      want = due_results.pop_front();
      if (got.val !== want.val) begin
        $error("data_line_value: expected %0d, actual %0d", want.val, got.val);
        fails++;
      end
      if (got.drv !== want.drv) begin
        $error("data_line_driven: expected %0d, actual %0d", want.drv, got.drv);
        fails++;
      end
      if (got.pulse !== want.pulse) begin
        $error("second_pulse: expected %0d, actual %0d", want.pulse, got.pulse);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_NONE;
  logic        clock_level = 1'b0;
  logic        chip_disabled = 1'b0;
  logic        data_in = 1'b0;
  logic [31:0] host_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        data_line_value;
  logic        data_line_driven;
  logic        second_pulse;
  logic [1:0]  status;

  rtc_event_checker rtc_model = new();

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          events_counted = 0;
  logic [31:0] host_now = '0;
  int          src_idle_by_phase [4] = '{0, 61, 0, 12};
  int          sink_stall_by_phase [4] = '{0, 0, 61, 12};

  serial_rtc_with_pram dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .clock_level      (clock_level),
    .chip_disabled    (chip_disabled),
    .data_in          (data_in),
    .host_seconds     (host_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .data_line_value  (data_line_value),
    .data_line_driven (data_line_driven),
    .second_pulse     (second_pulse),
    .status           (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        rtc_model.take_event(mode, clock_level, chip_disabled, data_in, host_seconds);
      if (out_valid && !out_stall)
        rtc_model.check_reply({data_line_value, data_line_driven, second_pulse,
                               status_t'(status)});
    end
  end

  // Presents one event word and returns at the edge that accepts it.
  task automatic put_event(logic [1:0] m, logic c, logic dis, logic di, logic [31:0] h);
    events_counted++;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    clock_level <= c;
    chip_disabled <= dis;
    data_in <= di;
    host_seconds <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic clock_in_bit(logic b);
    if ($urandom_range(3) == 0)
      put_event(MODE_CLOCK, 1'b0, 1'b0, 1'($urandom), $urandom);
    put_event(MODE_CLOCK, 1'b1, 1'b0, b, $urandom);
  endtask

  // Also used to clock a read byte out; the data line is ignored then.
  task automatic clock_in_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) clock_in_bit(b[i]);
  endtask

  task automatic deselect();
    put_event(MODE_ENABLE, 1'($urandom), 1'b1, 1'($urandom), $urandom);
  endtask

  function automatic logic [7:0] pick_addr();
    // Most addresses overlap the standard registers so reads find earlier writes.
    if ($urandom_range(2) == 0) return 8'($urandom);
    return 8'h08 + 8'($urandom_range(23));
  endfunction

  task automatic run_transaction();
    int kind;
    int sel;
    logic [7:0] addr;
    kind = $urandom_range(99);
    addr = pick_addr();
    deselect();
    if ($urandom_range(9) == 0)
      put_event(MODE_ENABLE, 1'($urandom), 1'b0, 1'($urandom), $urandom);
    if (kind < 10) begin
      clock_in_byte({1'b0, REG_WPROTECT, 2'($urandom_range(3))});
      clock_in_byte({($urandom_range(99) < 30), 7'($urandom_range(127))});
    end else if (kind < 32) begin
      clock_in_byte({1'b0, 5'($urandom_range(31)), 2'($urandom_range(3))});
      clock_in_byte(8'($urandom));
    end else if (kind < 50) begin
      clock_in_byte({1'b1, 5'($urandom_range(31)), 2'($urandom_range(3))});
      clock_in_byte(8'($urandom));
    end else if (kind < 68) begin
      clock_in_byte({1'b0, 4'b0111, addr[7:5]});
      clock_in_byte({1'($urandom), addr[4:0], 2'($urandom_range(3))});
      clock_in_byte(8'($urandom));
    end else if (kind < 84) begin
      clock_in_byte({1'b1, 4'b0111, addr[7:5]});
      clock_in_byte({1'($urandom), addr[4:0], 2'($urandom_range(3))});
      clock_in_byte(8'($urandom));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 3)) begin
        sel = $urandom_range(9);
        if (sel < 7) host_now = host_now + 32'($urandom_range(1, 5));
        else if (sel == 9) host_now = $urandom;
        put_event(MODE_TIME, 1'($urandom), 1'($urandom), 1'($urandom), host_now);
      end
    end else if (kind < 96) begin
      // One to fifteen bits, possibly ending in the middle of a byte or a read-out, then deselect.
      repeat ($urandom_range(1, 15)) clock_in_bit(1'($urandom));
      deselect();
    end else begin
      repeat (3) begin
        host_now = $urandom;
        put_event(2'($urandom_range(3)), 1'($urandom), 1'($urandom), 1'($urandom),
                  host_now);
      end
    end
  endtask

  initial begin
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    put_event(MODE_NONE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    put_event(MODE_NONE, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
    put_event(MODE_TIME, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
    put_event(MODE_TIME, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // The delta wraps to two and carries the counter past its top.
    put_event(MODE_TIME, 1'b0, 1'b0, 1'b0, 32'h0000_0001);
    host_now = 32'h0000_0001;
    put_event(MODE_CLOCK, 1'b0, 1'b0, 1'b1, 32'h0);
    put_event(MODE_CLOCK, 1'b1, 1'b1, 1'b1, 32'h0);
    put_event(MODE_ENABLE, 1'b1, 1'b0, 1'b1, 32'h0);
    clock_in_bit(1'b1);
    clock_in_bit(1'b0);
    clock_in_bit(1'b1);
    deselect();
    deselect();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_idle_by_phase[p];
      sink_stall_pct = sink_stall_by_phase[p];
      goal = events_counted + 160;
      while (events_counted < goal) run_transaction();
    end
    in_valid <= 1'b0;

    while (rtc_model.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (rtc_model.fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
